// ===== rtl/core/plenv_pkg.sv =====
// plenv_pkg: shared types and constants for the envelope reader
// breakpoint record, sequencer states and field widths
// no dependencies
`timescale 1ns / 1ps

package plenv_pkg;

    // field widths fixed by the item format
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int PINDEX_W = 6;
    localparam int FRAC_W   = 17;

    // default store depth
    localparam int DEF_MAX_POINTS = 64;

    // action codes
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one breakpoint as kept in the store
    typedef struct packed {
        logic [TIME_W-1:0]         time_us;
        logic signed [VALUE_W-1:0] value;
    } t_point;

    // query sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK0,
        ST_WALK,
        ST_LAST,
        ST_READA,
        ST_DIV,
        ST_SUM
    } t_state;

endpackage

// ===== rtl/core/plenv_store.sv =====
// plenv_store: breakpoint memory, one write port and one registered read port
// depends on plenv_pkg for the breakpoint record
`timescale 1ns / 1ps

module plenv_store #(
    parameter int MAX_POINTS = plenv_pkg::DEF_MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(MAX_POINTS)-1:0]   i_waddr,
    input  plenv_pkg::t_point               i_wdata,
    input  logic [$clog2(MAX_POINTS)-1:0]   i_raddr,
    output plenv_pkg::t_point               o_rdata
);
    import plenv_pkg::*;

    t_point mem [MAX_POINTS];
    t_point r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/plenv_div.sv =====
// plenv_div: radix-2 divider for the Q1.16 segment fraction
// one quotient bit per cycle, numerator not above the divisor
// depends on plenv_pkg for widths
`timescale 1ns / 1ps

module plenv_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [plenv_pkg::TIME_W-1:0]        i_num,
    input  logic [plenv_pkg::TIME_W-1:0]        i_den,
    output logic                                o_done,
    output logic [plenv_pkg::FRAC_W-1:0]        o_quot
);
    import plenv_pkg::*;

    localparam int STEPS = FRAC_W - 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_active, n_active;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TIME_W-1:0]  r_rem, n_rem;
    logic [TIME_W-1:0]  r_den, n_den;
    logic [FRAC_W-1:0]  r_quot, n_quot;
    logic [TIME_W:0]    shifted;
    logic               ge;
    logic               top_bit;

    // one restoring step on the partial remainder
    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_den};
    assign top_bit = i_num >= i_den;

    always_comb begin
        n_active = r_active;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_den    = r_den;
        n_quot   = r_quot;
        if (i_start) begin
            // integer bit of the quotient first, remainder stays below divisor
            n_active = 1'b1;
            n_cnt    = CNT_W'(STEPS);
            n_den    = i_den;
            n_rem    = top_bit ? (i_num - i_den) : i_num;
            n_quot   = FRAC_W'(top_bit);
        end else if (r_active) begin
            if (r_cnt != '0) begin
                n_rem  = ge ? TIME_W'(shifted - {1'b0, r_den}) : TIME_W'(shifted);
                n_quot = {r_quot[FRAC_W-2:0], ge};
                n_cnt  = r_cnt - 1'b1;
            end else begin
                n_active = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_active && (r_cnt == '0);
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/piecewise_linear_envelope_reader.sv =====
// piecewise_linear_envelope_reader: breakpoint envelope reader, top level
// holds the query sequencer, cursor and interpolation datapath
// depends on plenv_pkg, plenv_store and plenv_div
`timescale 1ns / 1ps

// Usage
// An item is taken when start is high and busy is low. A store item
// (i_action = 0) writes i_point_time / i_point_value into slot i_point_index
// in the cycle it is taken and rewinds the cursor; it gives no result and
// leaves busy low. A query item (i_action = 1) returns one value on o_value,
// marked by o_valid for exactly one cycle; the receiver cannot stall it.
// i_cfg_wr_en / i_cfg_wr_data write point_count and rewind the cursor; write
// it only while the block is idle.
// Query path: an empty store gives 0 without a read. Otherwise the first
// point is read; a time at or before it returns that point's value. Then the
// cursor walks forward one point at a time on the single memory read port.
// Past the last point, or with the cursor on the last point, the last value
// is returned; a zero span gives the later point's value and a query at or
// behind the cursor point gives that point's value. Otherwise the fraction
// comes from the bit-serial divider and the value is interpolated.
// Queries are taken one at a time; a query that reads the store holds busy
// high until the result cycle. Reset clears point_count and the cursor; the
// store contents stay undefined until written.
module piecewise_linear_envelope_reader #(
    parameter int MAX_POINTS = plenv_pkg::DEF_MAX_POINTS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_action,
    input  logic [plenv_pkg::PINDEX_W-1:0]          i_point_index,
    input  logic [plenv_pkg::TIME_W-1:0]            i_point_time,
    input  logic signed [plenv_pkg::VALUE_W-1:0]    i_point_value,
    input  logic [plenv_pkg::TIME_W-1:0]            i_query_time,
    input  logic                                    i_cfg_wr_en,
    input  logic [plenv_pkg::COUNT_W-1:0]           i_cfg_wr_data,
    output logic                                    o_valid,
    output logic signed [plenv_pkg::VALUE_W-1:0]    o_value
);
    import plenv_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PROD_W = VALUE_W + 1 + FRAC_W + 1;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_cursor, n_cursor;
    logic [COUNT_W-1:0]         r_point_count, n_point_count;
    logic [TIME_W-1:0]          r_qtime, n_qtime;
    t_point                     r_a, n_a;
    t_point                     r_b, n_b;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic                       r_valid, n_valid;
    logic signed [VALUE_W-1:0]  r_value, n_value;

    logic [EXT_W-1:0]           count_ext;
    logic [EXT_W-1:0]           n_eff;
    logic [IDX_W-1:0]           last;
    logic                       empty;
    logic                       store_ok;
    logic [IDX_W-1:0]           cursor_inc;

    logic                       mem_we;
    logic [IDX_W-1:0]           rd_addr;
    t_point                     wr_point;
    t_point                     rd_data;

    logic                       div_start;
    logic                       div_done;
    logic [FRAC_W-1:0]          div_quot;
    logic [TIME_W-1:0]          div_num;
    logic [TIME_W-1:0]          div_den;

    logic signed [VALUE_W:0]    diff;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [PROD_W-1:0]   mul_res;

    // effective point count and last valid slot
    assign count_ext  = EXT_W'(r_point_count);
    assign n_eff      = (count_ext > EXT_W'(MAX_POINTS)) ? EXT_W'(MAX_POINTS) : count_ext;
    assign last       = IDX_W'(n_eff - EXT_W'(1));
    assign empty      = (n_eff == '0);
    assign store_ok   = 32'(i_point_index) < 32'(MAX_POINTS);
    assign cursor_inc = r_cursor + 1'b1;

    assign wr_point.time_us = i_point_time;
    assign wr_point.value   = i_point_value;

    // breakpoint store
    plenv_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (IDX_W'(i_point_index)),
        .i_wdata (wr_point),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // segment fraction, point A arrives on rd_data in ST_READA
    assign div_num = r_qtime - rd_data.time_us;
    assign div_den = r_b.time_us - rd_data.time_us;

    plenv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // value step times fraction
    assign diff    = $signed({r_b.value[VALUE_W-1], r_b.value})
                   - $signed({r_a.value[VALUE_W-1], r_a.value});
    assign frac_s  = $signed({1'b0, div_quot});
    assign mul_res = diff * frac_s;

    // sequencer next state and datapath
    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_point_count = r_point_count;
        n_qtime       = r_qtime;
        n_a           = r_a;
        n_b           = r_b;
        n_prod        = r_prod;
        n_valid       = 1'b0;
        n_value       = r_value;
        mem_we        = 1'b0;
        rd_addr       = '0;
        div_start     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_action == ACT_STORE) begin
                        if (store_ok) begin
                            mem_we   = 1'b1;
                            n_cursor = '0;
                        end
                    end else if (empty) begin
                        n_valid = 1'b1;
                        n_value = '0;
                    end else begin
                        n_qtime = i_query_time;
                        rd_addr = '0;
                        n_state = ST_CHK0;
                    end
                end
            end
            ST_CHK0: begin
                // at or before the first point
                if (r_qtime <= rd_data.time_us) begin
                    n_valid = 1'b1;
                    n_value = rd_data.value;
                    n_state = ST_IDLE;
                end else if (r_cursor < last) begin
                    rd_addr = cursor_inc;
                    n_state = ST_WALK;
                end else begin
                    rd_addr = last;
                    n_state = ST_LAST;
                end
            end
            ST_WALK: begin
                // rd_data holds the point after the cursor
                if (r_qtime > rd_data.time_us) begin
                    n_cursor = cursor_inc;
                    if (cursor_inc < last) begin
                        rd_addr = cursor_inc + 1'b1;
                    end else begin
                        rd_addr = last;
                        n_state = ST_LAST;
                    end
                end else begin
                    n_b     = rd_data;
                    rd_addr = r_cursor;
                    n_state = ST_READA;
                end
            end
            ST_LAST: begin
                n_valid = 1'b1;
                n_value = rd_data.value;
                n_state = ST_IDLE;
            end
            ST_READA: begin
                n_a = rd_data;
                // zero span gives the later value, query behind A gives A
                if (r_b.time_us <= rd_data.time_us) begin
                    n_valid = 1'b1;
                    n_value = r_b.value;
                    n_state = ST_IDLE;
                end else if (r_qtime <= rd_data.time_us) begin
                    n_valid = 1'b1;
                    n_value = rd_data.value;
                    n_state = ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_prod  = mul_res;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                // floor of product / 2^16 added to A
                n_valid = 1'b1;
                n_value = r_a.value + $signed(r_prod[FRAC_W+VALUE_W-2:FRAC_W-1]);
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register write rewinds the cursor
        if (i_cfg_wr_en) begin
            n_point_count = i_cfg_wr_data;
            n_cursor      = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cursor      <= '0;
            r_point_count <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cursor      <= n_cursor;
            r_point_count <= n_point_count;
            r_valid       <= n_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_qtime <= n_qtime;
        r_a     <= n_a;
        r_b     <= n_b;
        r_prod  <= n_prod;
        r_value <= n_value;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_value = r_value;

`ifndef SYNTH
    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // the walk never runs past the last valid point
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cursor < last))
        else $error("cursor walk past last point");

    // an in-range store rewinds the cursor
    a_store_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_STORE) && store_ok) |=> (r_cursor == '0))
        else $error("store did not rewind cursor");

    // a result follows a query item or an active sequencer step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != ST_IDLE)
                    || ($past(start) && ($past(i_action) == ACT_QUERY)))
        else $error("result without a query");
`endif

endmodule
